@@ rtl/acc_cpu_pkg.sv @@
// Shared constants and types for the accumulator machine
`timescale 1ns / 1ps
package acc_cpu_pkg;
  localparam int MemBytes   = 2048;
  localparam int AddrW      = 11;
  localparam int WordW      = 16;
  localparam logic [AddrW-1:0] DataBaseRst = 11'd1024;

  // request functions
  localparam logic [1:0] FUNC_WR   = 2'd0;
  localparam logic [1:0] FUNC_RD   = 2'd1;
  localparam logic [1:0] FUNC_EXEC = 2'd2;

  // opcodes
  localparam logic [3:0] OP_EOC   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_READ  = 4'd3;
  localparam logic [3:0] OP_WRITE = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_MUL   = 4'd7;
  localparam logic [3:0] OP_DIV   = 4'd8;
  localparam logic [3:0] OP_MOD   = 4'd9;
  localparam logic [3:0] OP_NEG   = 4'd10;
  localparam logic [3:0] OP_NOP   = 4'd11;
  localparam logic [3:0] OP_JUMP  = 4'd12;
  localparam logic [3:0] OP_JNEG  = 4'd13;
  localparam logic [3:0] OP_JZERO = 4'd14;
  localparam logic [3:0] OP_HALT  = 4'd15;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;
endpackage

@@ rtl/acc_cpu_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module acc_cpu_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/acc_cpu_div.sv @@
// Iterative unsigned 16-bit restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module acc_cpu_div
  import acc_cpu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [WordW-1:0] quot_q, quot_d;
  logic [WordW:0]   rem_q, rem_d;
  logic [WordW-1:0] dvs_q, dvs_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WordW:0]   trial;

  // shift in one dividend bit and try the subtract
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[WordW-1:0], quot_q[WordW-1]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[WordW]) begin
        rem_d = {rem_q[WordW-1:0], quot_q[WordW-1]};
        quot_d = {quot_q[WordW-2:0], 1'b0};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[WordW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[WordW-1:0];
endmodule

@@ rtl/accumulator_cpu_core_unit.sv @@
// Top level of the accumulator machine: sequencer, registers, memory and divider
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: func_i,
//   byte_addr_i, byte_data_i. A request is taken when valid is high and stall
//   low. Exactly one result follows on the output channel (out_valid_o /
//   out_stall_i), held stable while the receiver stalls.
//   A byte write goes straight to the result; a byte read waits on the
//   registered RAM read. An instruction reads each memory word it needs
//   byte by byte (fetch, operand word, READ source word, WRITE output
//   word), writes the word of a STORE or READ, executes other opcodes and
//   presents the result. DIV and MOD wait on the bit-serial divider.
//   One request is in flight at a time; in_stall_o stays high until the
//   result has been taken, and out_stall_i holds the result in place.
//   After reset a clearing pass zeroes all MEM_BYTES bytes of memory, one
//   byte a cycle; no request is taken meanwhile. Configuration writes
//   (cfg_we_i) load data_base and the data pointer; the user must make them
//   only while no request is in flight, as the block does not enforce it.
module accumulator_cpu_core_unit
  import acc_cpu_pkg::*;
#(
  parameter int MEM_BYTES = MemBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [AddrW-1:0]  byte_addr_i,
  input  logic [7:0]        byte_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_byte_o,
  output logic [3:0]        op_code_o,
  output logic [AddrW-1:0]  op_field_o,
  output logic [WordW-1:0]  instr_word_o,
  output logic signed [WordW-1:0] acc_value_o,
  output logic [AddrW-1:0]  next_pc_o,
  output logic              print_valid_o,
  output logic [WordW-1:0]  print_value_o,
  output logic              div_zero_o,
  output logic              stopped_o
);
  localparam int MAW = $clog2(MEM_BYTES);

  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_BRD   = 5'd2;
  localparam logic [4:0] S_F0    = 5'd3;
  localparam logic [4:0] S_F1    = 5'd4;
  localparam logic [4:0] S_F2    = 5'd5;
  localparam logic [4:0] S_O0    = 5'd6;
  localparam logic [4:0] S_O1    = 5'd7;
  localparam logic [4:0] S_O2    = 5'd8;
  localparam logic [4:0] S_D0    = 5'd9;
  localparam logic [4:0] S_D1    = 5'd10;
  localparam logic [4:0] S_D2    = 5'd11;
  localparam logic [4:0] S_W0    = 5'd12;
  localparam logic [4:0] S_W1    = 5'd13;
  localparam logic [4:0] S_X0    = 5'd14;
  localparam logic [4:0] S_X1    = 5'd15;
  localparam logic [4:0] S_X2    = 5'd16;
  localparam logic [4:0] S_EXE   = 5'd17;
  localparam logic [4:0] S_DIVW  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;
  localparam logic [4:0] S_BRD2  = 5'd20;

  logic [4:0]       st_q, st_d;
  logic [MAW:0]     clr_q, clr_d;
  logic [AddrW-1:0] base_q, base_d, dp_q, dp_d, pc_q, pc_d;
  logic [WordW-1:0] acc_q, acc_d, ir_q, ir_d;
  logic [WordW-1:0] opw_q, opw_d, dw_q, dw_d, wv_q, wv_d;
  logic [AddrW-1:0] ea_q, ea_d;
  logic [1:0]       func_q, func_d;
  logic [AddrW-1:0] baddr_q, baddr_d;
  logic [7:0]       bdata_q, bdata_d;
  logic [7:0]       rb_q, rb_d;
  logic             pv_q, pv_d, dz_q, dz_d, stp_q, stp_d;
  logic [WordW-1:0] pval_q, pval_d;
  logic             neg_q, neg_d;

  logic             ram_we;
  logic [MAW-1:0]   ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;

  acc_cpu_ram #(.Width(8), .Depth(MEM_BYTES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  acc_cpu_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  logic [3:0]       opc;
  logic             mode;
  logic [AddrW-1:0] opn;
  logic             is_arith, is_mem;
  logic [WordW-1:0] src, acc_abs, res_signed;
  logic [WordW-1:0] prod;

  assign opc      = ir_q[15:12];
  assign mode     = ir_q[11];
  assign opn      = ir_q[AddrW-1:0];
  assign is_arith = (opc == OP_LOAD) || (opc == OP_ADD) || (opc == OP_SUB) ||
                    (opc == OP_MUL) || (opc == OP_DIV) || (opc == OP_MOD);
  assign is_mem   = (opc == OP_STORE) || (opc == OP_READ) || (opc == OP_WRITE);
  assign src      = mode ? {5'd0, opn} : opw_q;
  assign acc_abs  = acc_q[15] ? (16'd0 - acc_q) : acc_q;
  assign prod     = acc_q * src;
  assign res_signed = (opc == OP_DIV) ? drsp.quot : drsp.rem;

  function automatic logic is_arith_n(input logic [3:0] o);
    is_arith_n = (o == OP_LOAD) || (o == OP_ADD) || (o == OP_SUB) ||
                 (o == OP_MUL) || (o == OP_DIV) || (o == OP_MOD);
  endfunction

  function automatic logic is_mem_n(input logic [3:0] o);
    is_mem_n = (o == OP_STORE) || (o == OP_READ) || (o == OP_WRITE);
  endfunction

  // sequence memory accesses and execute
  always_comb begin
    st_d = st_q; clr_d = clr_q; base_d = base_q; dp_d = dp_q; pc_d = pc_q;
    acc_d = acc_q; ir_d = ir_q; opw_d = opw_q; dw_d = dw_q; wv_d = wv_q;
    ea_d = ea_q; func_d = func_q; baddr_d = baddr_q; bdata_d = bdata_q;
    rb_d = rb_q; pv_d = pv_q; dz_d = dz_q; stp_d = stp_q; pval_d = pval_q;
    neg_d = neg_q;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
    dreq.start = 1'b0; dreq.dividend = acc_abs; dreq.divisor = src;
    case (st_q)
      S_CLR: begin
        ram_we = 1'b1;
        ram_addr = clr_q[MAW-1:0];
        clr_d = clr_q + (MAW+1)'(1);
        if (clr_q == (MAW+1)'(MEM_BYTES - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i; baddr_d = byte_addr_i; bdata_d = byte_data_i;
          rb_d = '0; pv_d = 1'b0; pval_d = '0; dz_d = 1'b0; stp_d = 1'b0;
          case (func_i)
            FUNC_WR: begin
              ram_we = 1'b1; ram_addr = byte_addr_i; ram_wdata = byte_data_i;
              st_d = S_OUT;
            end
            FUNC_RD: begin
              ram_addr = byte_addr_i; st_d = S_BRD;
            end
            FUNC_EXEC: begin
              ram_addr = pc_q; st_d = S_F0;
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      // present the read address again
      S_BRD: begin
        ram_addr = baddr_q; st_d = S_BRD2;
      end
      S_BRD2: begin
        rb_d = ram_rdata; st_d = S_OUT;
      end
      S_F0: begin
        ram_addr = pc_q; st_d = S_F1;
      end
      S_F1: begin
        ir_d[15:8] = ram_rdata; ram_addr = pc_q + 11'd1; st_d = S_F2;
      end
      S_F2: begin
        ir_d[7:0] = ram_rdata;
        // operand word needed for direct arithmetic or indirect STORE, READ, WRITE
        if ((is_arith_n(ir_d[15:12]) && !ir_d[11]) || (is_mem_n(ir_d[15:12]) && ir_d[11])) begin
          ram_addr = ir_d[AddrW-1:0]; st_d = S_O0;
        end else begin
          ea_d = ir_d[AddrW-1:0];
          if (ir_d[15:12] == OP_READ) begin
            ram_addr = dp_q; st_d = S_D0;
          end else if (ir_d[15:12] == OP_WRITE) begin
            ram_addr = ir_d[AddrW-1:0]; st_d = S_X0;
          end else st_d = S_EXE;
        end
      end
      S_O0: begin
        ram_addr = opn; st_d = S_O1;
      end
      S_O1: begin
        opw_d[15:8] = ram_rdata; ram_addr = opn + 11'd1; st_d = S_O2;
      end
      S_O2: begin
        opw_d[7:0] = ram_rdata;
        ea_d = {opw_q[10:8], ram_rdata};
        if (opc == OP_READ) begin
          ram_addr = dp_q; st_d = S_D0;
        end else if (opc == OP_WRITE) begin
          ram_addr = {opw_q[10:8], ram_rdata}; st_d = S_X0;
        end else st_d = S_EXE;
      end
      S_D0: begin
        ram_addr = dp_q; st_d = S_D1;
      end
      S_D1: begin
        dw_d[15:8] = ram_rdata; ram_addr = dp_q + 11'd1; st_d = S_D2;
      end
      S_D2: begin
        dw_d[7:0] = ram_rdata; wv_d = {dw_q[15:8], ram_rdata};
        dp_d = dp_q + 11'd2; st_d = S_W0;
      end
      S_X0: begin
        ram_addr = ea_q; st_d = S_X1;
      end
      S_X1: begin
        pval_d[15:8] = ram_rdata; ram_addr = ea_q + 11'd1; st_d = S_X2;
      end
      S_X2: begin
        pval_d[7:0] = ram_rdata; pv_d = 1'b1;
        pc_d = pc_q + 11'd2; st_d = S_OUT;
      end
      S_W0: begin
        ram_we = 1'b1; ram_addr = ea_q; ram_wdata = wv_q[15:8]; st_d = S_W1;
      end
      S_W1: begin
        ram_we = 1'b1; ram_addr = ea_q + 11'd1; ram_wdata = wv_q[7:0];
        pc_d = pc_q + 11'd2; st_d = S_OUT;
      end
      S_EXE: begin
        pc_d = pc_q + 11'd2;
        st_d = S_OUT;
        case (opc)
          OP_EOC:   stp_d = 1'b1;
          OP_LOAD:  acc_d = src;
          OP_STORE: begin
            wv_d = acc_q; pc_d = pc_q; st_d = S_W0;
          end
          OP_ADD:   acc_d = acc_q + src;
          OP_SUB:   acc_d = acc_q - src;
          OP_MUL:   acc_d = prod;
          OP_DIV, OP_MOD: begin
            if (src == '0) dz_d = 1'b1;
            else begin
              dreq.start = 1'b1; neg_d = acc_q[15]; pc_d = pc_q; st_d = S_DIVW;
            end
          end
          OP_NEG:   acc_d = 16'd0 - acc_q;
          OP_JUMP:  pc_d = opn;
          OP_JNEG:  if (acc_q[15]) pc_d = opn;
          OP_JZERO: if (acc_q == '0) pc_d = opn;
          OP_HALT: begin
            stp_d = 1'b1; pc_d = pc_q;
          end
          default: ;
        endcase
      end
      S_DIVW: begin
        if (drsp.done) begin
          // quotient and remainder follow the dividend's sign
          acc_d = neg_q ? (16'd0 - res_signed) : res_signed;
          pc_d = pc_q + 11'd2; st_d = S_OUT;
        end
      end
      S_OUT: if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      base_d = cfg_wdata_i; dp_d = cfg_wdata_i;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; base_q <= DataBaseRst; dp_q <= DataBaseRst;
      pc_q <= '0; acc_q <= '0; ir_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; base_q <= base_d; dp_q <= dp_d;
      pc_q <= pc_d; acc_q <= acc_d; ir_q <= ir_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    opw_q <= opw_d; dw_q <= dw_d; wv_q <= wv_d; ea_q <= ea_d;
    func_q <= func_d; baddr_q <= baddr_d; bdata_q <= bdata_d;
    rb_q <= rb_d; pv_q <= pv_d; dz_q <= dz_d; stp_q <= stp_d;
    pval_q <= pval_d; neg_q <= neg_d;
  end

  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = (st_q == S_OUT);
  assign read_byte_o   = rb_q;
  assign op_code_o     = opc;
  assign op_field_o    = opn;
  assign instr_word_o  = ir_q;
  assign acc_value_o   = acc_q;
  assign next_pc_o     = pc_q;
  assign print_valid_o = pv_q;
  assign print_value_o = pval_q;
  assign div_zero_o    = dz_q;
  assign stopped_o     = stp_q;

  logic unused;
  assign unused = ^{func_q, bdata_q, base_q, dw_q[7:0], is_arith, is_mem};
endmodule
